>>> hdl/gid_pkg.sv
// ----------------------------------------------------------------------------
// gid_pkg: shared types and constants of the GPIO interrupt detector
// Item structs, opcode and register select codes, condition codes and the
// masks of the pins that exist on the port.
// ----------------------------------------------------------------------------
package gid_pkg;

  // Number of pins on the port, 1 to 32
  localparam int unsigned PinCount = 32;
  localparam int unsigned RegWidth = 32;

  // Item operations
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } opcode_e;

  // Register selects
  typedef enum logic [2:0] {
    SEL_COND_LOW  = 3'd0,
    SEL_COND_HIGH = 3'd1,
    SEL_MASK      = 3'd2,
    SEL_STATUS    = 3'd3,
    SEL_ANY_EDGE  = 3'd4
  } reg_sel_e;

  // Per-pin trigger condition
  typedef enum logic [1:0] {
    COND_LEVEL_LOW  = 2'd0,
    COND_LEVEL_HIGH = 2'd1,
    COND_RISING     = 2'd2,
    COND_FALLING    = 2'd3
  } cond_e;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [2:0]          reg_select;
    logic [RegWidth-1:0] write_data;
    logic [RegWidth-1:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [RegWidth-1:0] read_data;
    logic                irq_low;
    logic                irq_high;
  } out_item_t;

  // Bits of the pins that exist
  function automatic logic [RegWidth-1:0] pin_mask_f();
    logic [RegWidth-1:0] m;
    m = '0;
    for (int i = 0; i < RegWidth; i++) begin
      if (i < PinCount) m[i] = 1'b1;
    end
    return m;
  endfunction

  // Two-bit condition fields of pins base..base+15 that exist
  function automatic logic [RegWidth-1:0] cond_mask_f(int unsigned base);
    logic [RegWidth-1:0] m;
    m = '0;
    for (int k = 0; k < RegWidth / 2; k++) begin
      if (base + k < PinCount) m[2*k +: 2] = 2'b11;
    end
    return m;
  endfunction

  localparam logic [RegWidth-1:0] PinMask      = pin_mask_f();
  localparam logic [RegWidth-1:0] CondLowMask  = cond_mask_f(0);
  localparam logic [RegWidth-1:0] CondHighMask = cond_mask_f(RegWidth / 2);

endpackage

>>> hdl/gid_in_reg.sv
// ----------------------------------------------------------------------------
// gid_in_reg: input register stage
// Captures one item per beat and hands it to the detector logic as soon as
// the result register has room.
// ----------------------------------------------------------------------------
module gid_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gid_pkg::in_item_t in_item_i,
  input  logic              space_i,
  output logic              advance_o,
  output gid_pkg::in_item_t item_o
);
  import gid_pkg::*;

  logic     in_valid_q;
  in_item_t in_item_q;
  logic     load;

  // Move the held item on when the result side has room
  assign advance_o  = in_valid_q & space_i;
  assign in_ready_o = ~in_valid_q | advance_o;
  assign load       = in_valid_i & in_ready_o;
  assign item_o     = in_item_q;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= 1'b1;
    end else if (advance_o) begin
      in_valid_q <= 1'b0;
    end
  end

  // Hold the payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      in_item_q <= in_item_i;
    end
  end

endmodule

>>> hdl/gid_core.sv
// ----------------------------------------------------------------------------
// gid_core: interrupt registers and per-pin detection
// Holds condition, mask, status, any-edge and last-level registers, applies
// one tick, read or write per advance and forms the result item.
// ----------------------------------------------------------------------------
module gid_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  gid_pkg::in_item_t  item_i,
  output gid_pkg::out_item_t result_o
);
  import gid_pkg::*;

  logic [RegWidth-1:0]   cond_low_q, cond_low_d;
  logic [RegWidth-1:0]   cond_high_q, cond_high_d;
  logic [RegWidth-1:0]   mask_q, mask_d;
  logic [RegWidth-1:0]   status_q, status_d;
  logic [RegWidth-1:0]   any_edge_q, any_edge_d;
  logic [RegWidth-1:0]   last_q, last_d;
  logic [2*RegWidth-1:0] cond_all;
  logic [RegWidth-1:0]   hit;
  logic [RegWidth-1:0]   rdata;
  logic [RegWidth-1:0]   active;

  // Decide whether one pin's condition holds
  function automatic logic fire_f(logic any_edge, logic [1:0] code, logic now, logic was);
    logic f;
    if (any_edge) begin
      f = now ^ was;
    end else begin
      unique case (cond_e'(code))
        COND_LEVEL_LOW:  f = ~now;
        COND_LEVEL_HIGH: f = now;
        COND_RISING:     f = now & ~was;
        COND_FALLING:    f = was & ~now;
        default:         f = 1'b0;
      endcase
    end
    return f;
  endfunction

  // Evaluate every pin against its condition
  always_comb begin
    cond_all = {cond_high_q, cond_low_q};
    for (int i = 0; i < RegWidth; i++) begin
      hit[i] = fire_f(any_edge_q[i], cond_all[2*i +: 2], item_i.pin_levels[i], last_q[i]);
    end
  end

  // Apply the item to the registers
  always_comb begin
    cond_low_d  = cond_low_q;
    cond_high_d = cond_high_q;
    mask_d      = mask_q;
    status_d    = status_q;
    any_edge_d  = any_edge_q;
    last_d      = last_q;
    rdata       = '0;
    unique case (opcode_e'(item_i.opcode))
      OP_TICK: begin
        status_d = (status_q | hit) & PinMask;
        last_d   = item_i.pin_levels & PinMask;
      end
      OP_READ: begin
        unique case (reg_sel_e'(item_i.reg_select))
          SEL_COND_LOW:  rdata = cond_low_q;
          SEL_COND_HIGH: rdata = cond_high_q;
          SEL_MASK:      rdata = mask_q;
          SEL_STATUS:    rdata = status_q;
          SEL_ANY_EDGE:  rdata = any_edge_q;
          default:       rdata = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (reg_sel_e'(item_i.reg_select))
          SEL_COND_LOW:  cond_low_d  = item_i.write_data & CondLowMask;
          SEL_COND_HIGH: cond_high_d = item_i.write_data & CondHighMask;
          SEL_MASK:      mask_d      = item_i.write_data & PinMask;
          SEL_STATUS:    status_d    = status_q & ~item_i.write_data;
          SEL_ANY_EDGE:  any_edge_d  = item_i.write_data & PinMask;
          default:       ;
        endcase
      end
      default: ;
    endcase
  end

  // Form the result from the updated state
  assign active             = status_d & mask_d;
  assign result_o.read_data = rdata;
  assign result_o.irq_low   = |active[RegWidth/2-1:0];
  assign result_o.irq_high  = |active[RegWidth-1:RegWidth/2];

  // Commit state on each advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cond_low_q  <= '0;
      cond_high_q <= '0;
      mask_q      <= '0;
      status_q    <= '0;
      any_edge_q  <= '0;
      last_q      <= '0;
    end else if (advance_i) begin
      cond_low_q  <= cond_low_d;
      cond_high_q <= cond_high_d;
      mask_q      <= mask_d;
      status_q    <= status_d;
      any_edge_q  <= any_edge_d;
      last_q      <= last_d;
    end
  end

endmodule

>>> hdl/gid_out_reg.sv
// ----------------------------------------------------------------------------
// gid_out_reg: result register
// Holds one result beat until the consumer takes it and reports whether a
// new result can be loaded this cycle.
// ----------------------------------------------------------------------------
module gid_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  gid_pkg::out_item_t result_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gid_pkg::out_item_t out_item_o
);
  import gid_pkg::*;

  logic      out_valid_q;
  out_item_t out_item_q;

  // Room when empty or when the held beat leaves now
  assign space_o     = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_item_q <= result_i;
    end
  end

endmodule

>>> hdl/gpio_interrupt_detector.sv
// Flow: an accepted item waits in the input register until the result register
// has room, and its result is then registered in the output register.
// Throughput: one item per cycle while the output is not stalled.
// Reset: rst_ni low clears all interrupt registers, the last pin levels and
// both valid flags at once; no clearing pass follows.
// ----------------------------------------------------------------------------
// gpio_interrupt_detector: GPIO port interrupt unit
// Edge and level detection, mask and sticky status for up to 32 pins, with
// register access carried on the same item channel.
// ----------------------------------------------------------------------------
module gpio_interrupt_detector (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gid_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gid_pkg::out_item_t out_item_o
);
  import gid_pkg::*;

  in_item_t  item;
  out_item_t result;
  logic      advance;
  logic      space;

  // Capture incoming beats
  gid_in_reg u_gid_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .space_i    (space),
    .advance_o  (advance),
    .item_o     (item)
  );

  // Detect and update registers
  gid_core u_gid_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .result_o  (result)
  );

  // Hold results for the consumer
  gid_out_reg u_gid_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (result),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> hdl/gid_checker.sv
// ----------------------------------------------------------------------------
// gid_checker: port-level checks of the GPIO interrupt detector
// Watches the two handshakes for stall, flow and reset behavior.
// ----------------------------------------------------------------------------
module gid_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input gid_pkg::out_item_t out_item_o
);
  import gid_pkg::*;

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result beat changed or dropped");

  // Stall the input only behind a stalled full output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output could drain");

  // Deliver an accepted beat when the output drains while it sits in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i |=> out_valid_o)
    else $error("accepted beat did not reach the output");

  // Drop result valid once reset has been seen at an edge
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind gpio_interrupt_detector gid_checker u_gid_checker (.*);
